FILE: sv/vdd_pkg.sv
// shared types, constants, operation codes and saturating helpers for the diffusion step
`timescale 1ns / 1ps

package vdd_pkg;

    localparam int MAX_CELLS = 2048;
    localparam int FRAC_BITS = 48;
    localparam int DW        = 64;
    localparam int CFG_W     = 63;
    localparam int CNT_W     = 16;
    localparam int OP_W      = 5;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CELLS + 1);

    localparam logic signed [DW-1:0] Q_THREE       = DW'(64'sd3 <<< FRAC_BITS);
    localparam logic signed [DW-1:0] Q_NINE_HALVES = DW'(64'sd9 <<< (FRAC_BITS - 1));

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_INV_SP_SQ  = 2'd1;
    localparam logic [1:0] CFG_INV_TWO_SP = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_INNER    = 2'd1;
    localparam logic [1:0] KIND_OUTER    = 2'd2;

    // datapath operation codes
    localparam logic [OP_W-1:0] OP_UNEW   = 5'd0;
    localparam logic [OP_W-1:0] OP_A1     = 5'd1;
    localparam logic [OP_W-1:0] OP_A2     = 5'd2;
    localparam logic [OP_W-1:0] OP_A3     = 5'd3;
    localparam logic [OP_W-1:0] OP_M1     = 5'd4;
    localparam logic [OP_W-1:0] OP_M2     = 5'd5;
    localparam logic [OP_W-1:0] OP_M3     = 5'd6;
    localparam logic [OP_W-1:0] OP_M4     = 5'd7;
    localparam logic [OP_W-1:0] OP_A5     = 5'd8;
    localparam logic [OP_W-1:0] OP_M5     = 5'd9;
    localparam logic [OP_W-1:0] OP_A6     = 5'd10;
    localparam logic [OP_W-1:0] OP_M6     = 5'd11;
    localparam logic [OP_W-1:0] OP_M7     = 5'd12;
    localparam logic [OP_W-1:0] OP_UPD    = 5'd13;
    localparam logic [OP_W-1:0] OP_EMIT_I = 5'd14;
    localparam logic [OP_W-1:0] OP_C0     = 5'd15;
    localparam logic [OP_W-1:0] OP_C1     = 5'd16;
    localparam logic [OP_W-1:0] OP_C2     = 5'd17;
    localparam logic [OP_W-1:0] OP_WIN    = 5'd18;
    localparam logic [OP_W-1:0] OP_XA     = 5'd19;
    localparam logic [OP_W-1:0] OP_XB     = 5'd20;
    localparam logic [OP_W-1:0] OP_XS     = 5'd21;
    localparam logic [OP_W-1:0] OP_XF     = 5'd22;
    localparam logic [OP_W-1:0] OP_EMIT_H = 5'd23;
    localparam logic [OP_W-1:0] OP_EMIT_T = 5'd24;
    localparam logic [OP_W-1:0] OP_CLR    = 5'd25;

    typedef struct packed {
        logic            take;
        logic            go;
        logic [OP_W-1:0] op;
        logic [1:0]      xsel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic out_free;
        logic idx_ge2;
        logic fin;
    } t_status;

    function automatic logic is_mul(input logic [OP_W-1:0] op);
        logic r;
        case (op) inside
            OP_UNEW, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7,
            OP_C0, OP_C1, OP_C2, OP_XA, OP_XB: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_emit(input logic [OP_W-1:0] op);
        return (op == OP_EMIT_I) || (op == OP_EMIT_H) || (op == OP_EMIT_T);
    endfunction

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        logic signed [DW-1:0] r;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        logic signed [DW-1:0] r;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/viscous_disk_diffusion_step.sv
// top level of the explicit viscous disk diffusion step
`timescale 1ns / 1ps

// Cells stream in on the input channel (valid/ready), inner ghost first, the
// outer ghost flagged by final_cell. Each cell after the first two yields one
// interior word for the cell before it; the final cell adds the inner and
// outer ghost words, the outer one flagged by final_result.
// Configuration (time step, 1/dr^2, 1/(2 dr)) is to be written through a
// plain write port only while no cell is in flight; the block does not
// enforce this. The 63-bit data is used as a non-negative value. All
// products run through one shared multiplier that takes one 32x32 partial
// product a cycle. A cell that yields an interior word takes 11 products
// plus the add, update, emit and window steps; the first two cells take 4
// products plus the window step. The final cell adds 8 products and 11
// steps for the ghosts. A new cell is taken only when the previous one is
// done. Results sit in an output register; if the receiver stalls, the
// sequencer waits at its emit step until the held word is taken. Reset
// (synchronous, active low) clears the configuration registers, the sweep
// and sequencer state and the output valid; the block is ready on release.
module viscous_disk_diffusion_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [vdd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_density,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_visc,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_visc_recip,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_radius_recip,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_press_factor,
    input  logic                            i_final_cell,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [vdd_pkg::DW-1:0]   o_new_density,
    output logic signed [vdd_pkg::DW-1:0]   o_new_pressure,
    output logic [1:0]                      o_cell_kind,
    output logic                            o_final_result
);

    vdd_pkg::t_cmd    w_cmd;
    vdd_pkg::t_status w_status;

    // sequencer
    vdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    vdd_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_cell_density      (i_cell_density),
        .i_cell_visc         (i_cell_visc),
        .i_cell_visc_recip   (i_cell_visc_recip),
        .i_cell_radius_recip (i_cell_radius_recip),
        .i_cell_press_factor (i_cell_press_factor),
        .i_final_cell        (i_final_cell),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_new_density       (o_new_density),
        .o_new_pressure      (o_new_pressure),
        .o_cell_kind         (o_cell_kind),
        .o_final_result      (o_final_result)
    );

endmodule

FILE: sv/vdd_qmul.sv
// multicycle saturating fixed-point multiplier, one 32x32 partial product a cycle
`timescale 1ns / 1ps

module vdd_qmul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [vdd_pkg::DW-1:0]    i_a,
    input  logic signed [vdd_pkg::DW-1:0]    i_b,
    output logic                             o_done,
    output logic signed [vdd_pkg::DW-1:0]    o_y
);

    localparam int AW = 2 * vdd_pkg::DW;
    localparam logic [AW-1:0] HALF = AW'(1) << (vdd_pkg::FRAC_BITS - 1);

    logic            r_busy, n_busy;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_done, n_done;
    logic            r_neg;
    logic [63:0]     r_xm, r_ym;
    logic [AW-1:0]   r_acc;
    logic signed [vdd_pkg::DW-1:0] r_y;

    logic [31:0]     w_xp, w_yp;
    logic [63:0]     w_pp;
    logic [AW-1:0]   w_pp_sh;
    logic [63:0]     w_q;
    logic            w_ovf;
    logic signed [vdd_pkg::DW-1:0] w_y;

    // partial product select
    always_comb begin
        w_xp    = r_xm[31:0];
        w_yp    = r_ym[31:0];
        w_pp_sh = '0;
        case (r_cnt[1:0])
            2'd0: begin w_xp = r_xm[31:0];  w_yp = r_ym[31:0];  end
            2'd1: begin w_xp = r_xm[31:0];  w_yp = r_ym[63:32]; end
            2'd2: begin w_xp = r_xm[63:32]; w_yp = r_ym[31:0];  end
            default: begin w_xp = r_xm[63:32]; w_yp = r_ym[63:32]; end
        endcase
        w_pp = w_xp * w_yp;
        case (r_cnt[1:0])
            2'd0:    w_pp_sh = AW'(w_pp);
            2'd1:    w_pp_sh = AW'(w_pp) << 32;
            2'd2:    w_pp_sh = AW'(w_pp) << 32;
            default: w_pp_sh = AW'(w_pp) << 64;
        endcase
    end

    // rounding was folded into the accumulator start value; saturate here
    always_comb begin
        w_ovf = (r_acc[AW-1:vdd_pkg::FRAC_BITS+64] != '0);
        w_q   = r_acc[vdd_pkg::FRAC_BITS+63:vdd_pkg::FRAC_BITS];
        if (r_neg) begin
            if (w_ovf || w_q[63]) begin
                w_y = {1'b1, 63'd0};
            end else begin
                w_y = -$signed(w_q);
            end
        end else begin
            if (w_ovf || w_q[63]) begin
                w_y = {1'b0, {63{1'b1}}};
            end else begin
                w_y = $signed(w_q);
            end
        end
    end

    // control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[63] ^ i_b[63];
            r_xm  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ym  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_acc <= HALF;
        end else if (r_busy && r_cnt != 3'd4) begin
            r_acc <= r_acc + w_pp_sh;
        end
        if (r_busy && r_cnt == 3'd4) begin
            r_y <= w_y;
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

FILE: sv/vdd_ctrl.sv
// operation sequencer for the diffusion step
`timescale 1ns / 1ps

module vdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vdd_pkg::t_status  i_status,
    output vdd_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [vdd_pkg::OP_W-1:0]   r_op, n_op;
    logic [1:0]                 r_xsel, n_xsel;
    logic [vdd_pkg::OP_W-1:0]   w_next;
    logic                       w_take;

    // successor of the current operation
    always_comb begin
        w_next = vdd_pkg::OP_CLR;
        case (r_op)
            vdd_pkg::OP_UNEW:   w_next = i_status.idx_ge2 ? vdd_pkg::OP_A1 : vdd_pkg::OP_C0;
            vdd_pkg::OP_A1:     w_next = vdd_pkg::OP_A2;
            vdd_pkg::OP_A2:     w_next = vdd_pkg::OP_A3;
            vdd_pkg::OP_A3:     w_next = vdd_pkg::OP_M1;
            vdd_pkg::OP_M1:     w_next = vdd_pkg::OP_M2;
            vdd_pkg::OP_M2:     w_next = vdd_pkg::OP_M3;
            vdd_pkg::OP_M3:     w_next = vdd_pkg::OP_M4;
            vdd_pkg::OP_M4:     w_next = vdd_pkg::OP_A5;
            vdd_pkg::OP_A5:     w_next = vdd_pkg::OP_M5;
            vdd_pkg::OP_M5:     w_next = vdd_pkg::OP_A6;
            vdd_pkg::OP_A6:     w_next = vdd_pkg::OP_M6;
            vdd_pkg::OP_M6:     w_next = vdd_pkg::OP_M7;
            vdd_pkg::OP_M7:     w_next = vdd_pkg::OP_UPD;
            vdd_pkg::OP_UPD:    w_next = vdd_pkg::OP_EMIT_I;
            vdd_pkg::OP_EMIT_I: w_next = vdd_pkg::OP_C0;
            vdd_pkg::OP_C0:     w_next = vdd_pkg::OP_C1;
            vdd_pkg::OP_C1:     w_next = vdd_pkg::OP_C2;
            vdd_pkg::OP_C2:     w_next = vdd_pkg::OP_WIN;
            vdd_pkg::OP_WIN:    w_next = vdd_pkg::OP_XA;
            vdd_pkg::OP_XA:     w_next = vdd_pkg::OP_XB;
            vdd_pkg::OP_XB:     w_next = vdd_pkg::OP_XS;
            vdd_pkg::OP_XS:     w_next = vdd_pkg::OP_XF;
            vdd_pkg::OP_XF: begin
                if (r_xsel == 2'd1) begin
                    w_next = vdd_pkg::OP_EMIT_H;
                end else if (r_xsel == 2'd3) begin
                    w_next = vdd_pkg::OP_EMIT_T;
                end else begin
                    w_next = vdd_pkg::OP_XA;
                end
            end
            vdd_pkg::OP_EMIT_H: w_next = vdd_pkg::OP_XA;
            vdd_pkg::OP_EMIT_T: w_next = vdd_pkg::OP_CLR;
            default:            w_next = vdd_pkg::OP_CLR;
        endcase
    end

    assign w_take = (r_state == ST_IDLE) && i_in_valid;

    // state machine
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_xsel  = r_xsel;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_RUN;
                    n_op    = vdd_pkg::OP_UNEW;
                    n_xsel  = 2'd0;
                end
            end
            ST_RUN: begin
                if (vdd_pkg::is_mul(r_op)) begin
                    n_state = ST_MUL;
                end else if (vdd_pkg::is_emit(r_op) && !i_status.out_free) begin
                    n_state = ST_RUN;
                end else if (r_op == vdd_pkg::OP_CLR) begin
                    n_state = ST_IDLE;
                end else if (r_op == vdd_pkg::OP_WIN && !i_status.fin) begin
                    n_state = ST_IDLE;
                end else begin
                    n_op = w_next;
                    if (r_op == vdd_pkg::OP_XF) begin
                        n_xsel = r_xsel + 2'd1;
                    end
                end
            end
            ST_MUL: begin
                if (i_status.mul_done) begin
                    n_state = ST_RUN;
                    n_op    = w_next;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= vdd_pkg::OP_UNEW;
            r_xsel  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_xsel  <= n_xsel;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.take = w_take;
    assign o_cmd.go   = (r_state == ST_RUN);
    assign o_cmd.op   = r_op;
    assign o_cmd.xsel = r_xsel;

    // checks
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == ST_RUN) && (r_op == vdd_pkg::OP_UNEW))
        else $error("accepted word did not start the sequence");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.mul_done |-> (r_state == ST_MUL))
        else $error("multiplier finished outside a multiply wait");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && vdd_pkg::is_emit(r_op) && !i_status.out_free)
        |=> (r_op == $past(r_op)) && (r_state == ST_RUN))
        else $error("emit step left while output register was full");

endmodule

FILE: sv/vdd_datapath.sv
// registers, stencil arithmetic, extrapolation and output register
`timescale 1ns / 1ps

module vdd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vdd_pkg::t_cmd                   i_cmd,
    output vdd_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [vdd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_density,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_visc,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_visc_recip,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_radius_recip,
    input  logic signed [vdd_pkg::DW-1:0]   i_cell_press_factor,
    input  logic                            i_final_cell,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [vdd_pkg::DW-1:0]   o_new_density,
    output logic signed [vdd_pkg::DW-1:0]   o_new_pressure,
    output logic [1:0]                      o_cell_kind,
    output logic                            o_final_result
);

    typedef logic signed [vdd_pkg::DW-1:0] t_word;

    logic [vdd_pkg::CFG_W-1:0] r_ts, r_iss, r_its;
    t_word r_dens, r_visc, r_vrec, r_rrec, r_pfac;
    logic  r_fin;
    logic [vdd_pkg::CNT_W-1:0] r_count;
    t_word r_win [2];
    t_word r_coef [4];
    t_word r_head [6];
    t_word r_tail [6];
    t_word r_unew, r_lap, r_grad, r_t1, r_t2, r_nd, r_np, r_e1, r_e2, r_xd, r_xp;
    logic  r_ovalid;
    t_word r_od, r_op;
    logic [1:0] r_okind;
    logic  r_ofin;

    logic  w_start, w_done, w_out_free, w_load;
    t_word w_ma, w_mb, w_my, w_near, w_mid, w_far;
    t_word w_od, w_op;
    logic [1:0] w_kind;
    logic  w_ofin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= '0;
            r_iss <= '0;
            r_its <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vdd_pkg::CFG_TIME_STEP:  r_ts  <= i_cfg_data;
                vdd_pkg::CFG_INV_SP_SQ:  r_iss <= i_cfg_data;
                vdd_pkg::CFG_INV_TWO_SP: r_its <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // extrapolation operand select
    always_comb begin
        case (i_cmd.xsel)
            2'd0:    begin w_near = r_head[0]; w_mid = r_head[1]; w_far = r_head[2]; end
            2'd1:    begin w_near = r_head[3]; w_mid = r_head[4]; w_far = r_head[5]; end
            2'd2:    begin w_near = r_tail[2]; w_mid = r_tail[1]; w_far = r_tail[0]; end
            default: begin w_near = r_tail[5]; w_mid = r_tail[4]; w_far = r_tail[3]; end
        endcase
    end

    // multiplier operand select
    always_comb begin
        w_ma = r_dens;
        w_mb = r_visc;
        case (i_cmd.op)
            vdd_pkg::OP_UNEW: begin w_ma = r_dens; w_mb = r_visc; end
            vdd_pkg::OP_M1:   begin w_ma = r_lap;  w_mb = t_word'({1'b0, r_iss}); end
            vdd_pkg::OP_M2:   begin w_ma = r_coef[0]; w_mb = r_t1; end
            vdd_pkg::OP_M3:   begin w_ma = r_grad; w_mb = t_word'({1'b0, r_its}); end
            vdd_pkg::OP_M4:   begin w_ma = r_coef[1]; w_mb = r_t2; end
            vdd_pkg::OP_M5:   begin w_ma = t_word'({1'b0, r_ts}); w_mb = r_t1; end
            vdd_pkg::OP_M6:   begin w_ma = r_t1;   w_mb = r_coef[2]; end
            vdd_pkg::OP_M7:   begin w_ma = r_nd;   w_mb = r_coef[3]; end
            vdd_pkg::OP_C0:   begin w_ma = r_visc; w_mb = vdd_pkg::Q_THREE; end
            vdd_pkg::OP_C1:   begin w_ma = r_visc; w_mb = r_rrec; end
            vdd_pkg::OP_C2:   begin w_ma = r_t2;   w_mb = vdd_pkg::Q_NINE_HALVES; end
            vdd_pkg::OP_XA:   begin w_ma = w_near; w_mb = vdd_pkg::Q_THREE; end
            vdd_pkg::OP_XB:   begin w_ma = w_mid;  w_mb = vdd_pkg::Q_THREE; end
            default:          begin w_ma = r_dens; w_mb = r_visc; end
        endcase
    end

    assign w_start = i_cmd.go && vdd_pkg::is_mul(i_cmd.op);

    vdd_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_y     (w_my)
    );

    // output word select
    always_comb begin
        w_od   = r_nd;
        w_op   = r_np;
        w_kind = vdd_pkg::KIND_INTERIOR;
        w_ofin = 1'b0;
        case (i_cmd.op)
            vdd_pkg::OP_EMIT_H: begin
                w_od = r_xd; w_op = r_xp; w_kind = vdd_pkg::KIND_INNER;
            end
            vdd_pkg::OP_EMIT_T: begin
                w_od = r_xd; w_op = r_xp; w_kind = vdd_pkg::KIND_OUTER; w_ofin = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_load     = i_cmd.go && vdd_pkg::is_emit(i_cmd.op) && w_out_free;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_od    <= w_od;
            r_op    <= w_op;
            r_okind <= w_kind;
            r_ofin  <= w_ofin;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dens <= i_cell_density;
            r_visc <= i_cell_visc;
            r_vrec <= i_cell_visc_recip;
            r_rrec <= i_cell_radius_recip;
            r_pfac <= i_cell_press_factor;
            r_fin  <= i_final_cell;
        end
    end

    // sweep state: window, coefficients, head, tail, cell count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_win   <= '{default: '0};
            r_coef  <= '{default: '0};
            r_head  <= '{default: '0};
            r_tail  <= '{default: '0};
        end else if (i_cmd.go) begin
            case (i_cmd.op)
                vdd_pkg::OP_UPD: begin
                    case (r_count)
                        16'd2: begin r_head[0] <= r_nd; r_head[3] <= r_np; end
                        16'd3: begin r_head[1] <= r_nd; r_head[4] <= r_np; end
                        16'd4: begin r_head[2] <= r_nd; r_head[5] <= r_np; end
                        default: ;
                    endcase
                    r_tail[0] <= r_tail[1];
                    r_tail[1] <= r_tail[2];
                    r_tail[2] <= r_nd;
                    r_tail[3] <= r_tail[4];
                    r_tail[4] <= r_tail[5];
                    r_tail[5] <= r_np;
                end
                vdd_pkg::OP_WIN: begin
                    r_win[0]  <= r_win[1];
                    r_win[1]  <= r_unew;
                    r_coef[2] <= r_vrec;
                    r_coef[3] <= r_pfac;
                    if (!r_fin && r_count < vdd_pkg::CNT_LIMIT) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                vdd_pkg::OP_CLR: begin
                    r_count <= '0;
                    r_win   <= '{default: '0};
                    r_coef  <= '{default: '0};
                    r_head  <= '{default: '0};
                    r_tail  <= '{default: '0};
                end
                default: ;
            endcase
        end else if (w_done) begin
            case (i_cmd.op)
                vdd_pkg::OP_C0: r_coef[0] <= w_my;
                vdd_pkg::OP_C2: r_coef[1] <= w_my;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            case (i_cmd.op)
                vdd_pkg::OP_A1: r_lap <= vdd_pkg::sat_add(r_win[1], r_win[1]);
                vdd_pkg::OP_A2: r_lap <= vdd_pkg::sat_sub(r_unew, r_lap);
                vdd_pkg::OP_A3: begin
                    r_lap  <= vdd_pkg::sat_add(r_lap, r_win[0]);
                    r_grad <= vdd_pkg::sat_sub(r_unew, r_win[0]);
                end
                vdd_pkg::OP_A5: r_t1 <= vdd_pkg::sat_add(r_t1, r_t2);
                vdd_pkg::OP_A6: r_t1 <= vdd_pkg::sat_add(r_win[1], r_t1);
                vdd_pkg::OP_XS: r_e1 <= vdd_pkg::sat_sub(r_e1, r_e2);
                vdd_pkg::OP_XF: begin
                    if (!i_cmd.xsel[0]) begin
                        r_xd <= vdd_pkg::sat_add(r_e1, w_far);
                    end else begin
                        r_xp <= vdd_pkg::sat_add(r_e1, w_far);
                    end
                end
                default: ;
            endcase
        end else if (w_done) begin
            case (i_cmd.op)
                vdd_pkg::OP_UNEW: r_unew <= w_my;
                vdd_pkg::OP_M1:   r_t1   <= w_my;
                vdd_pkg::OP_M2:   r_t1   <= w_my;
                vdd_pkg::OP_M3:   r_t2   <= w_my;
                vdd_pkg::OP_M4:   r_t2   <= w_my;
                vdd_pkg::OP_M5:   r_t1   <= w_my;
                vdd_pkg::OP_M6:   r_nd   <= w_my;
                vdd_pkg::OP_M7:   r_np   <= w_my;
                vdd_pkg::OP_C1:   r_t2   <= w_my;
                vdd_pkg::OP_XA:   r_e1   <= w_my;
                vdd_pkg::OP_XB:   r_e2   <= w_my;
                default: ;
            endcase
        end
    end

    assign o_status.mul_done = w_done;
    assign o_status.out_free = w_out_free;
    assign o_status.idx_ge2  = (r_count >= 16'd2);
    assign o_status.fin      = r_fin;

    assign o_out_valid    = r_ovalid;
    assign o_new_density  = r_od;
    assign o_new_pressure = r_op;
    assign o_cell_kind    = r_okind;
    assign o_final_result = r_ofin;

    // checks
    a_fin_is_outer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofin) |-> (r_okind == vdd_pkg::KIND_OUTER))
        else $error("final word is not the outer ghost");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && i_cmd.op == vdd_pkg::OP_CLR) |=> (r_count == '0))
        else $error("cell count not cleared after final cell");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vdd_pkg::CNT_LIMIT)
        else $error("cell count beyond its saturation limit");

endmodule
